// ----- rtl/knn_pkg.sv -----
package knn_pkg;

  localparam int DIST_W = 32;
  localparam int IDX_W  = 16;
  localparam int RANK_W = 5;
  localparam int CFG_W  = 6;
  localparam int K_RESET_VALUE = 20;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  candidate_index;
    logic              last_candidate;
  } knn_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  neighbor_index;
    logic [DIST_W-1:0] neighbor_distance;
    logic [RANK_W-1:0] rank;
    logic              last_result;
  } knn_out_t;

  // contents of one cell of the sorted list
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } knn_entry_t;

  // per-cycle control of each cell; insert and shift are shared by every cell
  typedef struct packed {
    logic insert;
    logic shift;
    logic active;
  } knn_cell_ctrl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } knn_state_t;

endpackage

// ----- rtl/knn_cell.sv -----
module knn_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  knn_pkg::knn_cell_ctrl_t ctrl,
  input  logic [knn_pkg::DIST_W-1:0] new_dist,
  input  logic [knn_pkg::IDX_W-1:0]  new_idx,
  input  logic                  prev_take,
  input  knn_pkg::knn_entry_t   prev_entry,
  input  knn_pkg::knn_entry_t   next_entry,
  output logic                  take,
  output knn_pkg::knn_entry_t   entry
);
  import knn_pkg::*;

  knn_entry_t entry_next;

  // empty slot counts as infinity, ties keep the older entry ahead
  assign take = ctrl.active && (!entry.valid || (new_dist < entry.distance));

  always_comb begin
    entry_next = entry;
    if (ctrl.insert) begin
      if (!ctrl.active) begin
        entry_next.valid = 1'b0;
      end else if (prev_take) begin
        entry_next = prev_entry;
      end else if (take) begin
        entry_next.valid    = 1'b1;
        entry_next.distance = new_dist;
        entry_next.idx      = new_idx;
      end
    end else if (ctrl.shift) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry.valid <= entry_next.valid;
    end
    entry.distance <= entry_next.distance;
    entry.idx      <= entry_next.idx;
  end

endmodule

// ----- rtl/knn_topk_selector.sv -----
// results of a query are offered from the cycle after its last candidate is taken
// throughput: one candidate per cycle while collecting; after the last candidate
//   the list drains one neighbor per cycle while out_ready is high, input stalled
// the insertion point is found by every active cell comparing in parallel
// reset: synchronous, empties the list and sets the neighbor count to 20 (or MAX_NEIGHBORS if smaller)
module knn_topk_selector #(
  parameter int MAX_NEIGHBORS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  knn_pkg::knn_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output knn_pkg::knn_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [knn_pkg::CFG_W-1:0]     cfg_data
);
  import knn_pkg::*;

  localparam int KW = $clog2(MAX_NEIGHBORS + 1);
  localparam int CW = (KW > CFG_W) ? KW : CFG_W;
  localparam int K_RESET = (K_RESET_VALUE > MAX_NEIGHBORS) ? MAX_NEIGHBORS : K_RESET_VALUE;

  knn_state_t        state, state_next;
  logic [KW-1:0]     k_eff;
  logic [CW-1:0]     cfg_ext;
  logic [RANK_W-1:0] rank, rank_next;
  logic              in_fire, out_fire;

  knn_entry_t        entries [MAX_NEIGHBORS+1];
  logic              takes   [MAX_NEIGHBORS];

  assign cfg_ready = 1'b1;
  assign cfg_ext   = CW'(cfg_data);

  // clamp the written count into 1..MAX_NEIGHBORS
  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff <= KW'(K_RESET);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_ext == '0) begin
        k_eff <= KW'(1);
      end else if (cfg_ext > CW'(MAX_NEIGHBORS)) begin
        k_eff <= KW'(MAX_NEIGHBORS);
      end else begin
        k_eff <= KW'(cfg_ext);
      end
    end
  end

  assign in_ready  = (state == ST_COLLECT);
  assign out_valid = (state == ST_DRAIN);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    state_next = state;
    rank_next  = rank;
    case (state)
      ST_COLLECT: begin
        rank_next = '0;
        if (in_fire && in_data.last_candidate) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          rank_next = rank + RANK_W'(1);
          if (!entries[1].valid) begin
            state_next = ST_COLLECT;
          end
        end
      end
      default: begin
        state_next = ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
      rank  <= '0;
    end else begin
      state <= state_next;
      rank  <= rank_next;
    end
  end

  assign entries[MAX_NEIGHBORS] = '0;

  for (genvar g = 0; g < MAX_NEIGHBORS; g++) begin : g_cell
    knn_cell_ctrl_t ctrl;
    logic           prev_take;
    knn_entry_t     prev_entry;

    assign ctrl.insert = in_fire;
    assign ctrl.shift  = out_fire;
    assign ctrl.active = (k_eff > KW'(g));

    if (g == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_take  = takes[g-1];
      assign prev_entry = entries[g-1];
    end

    knn_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_dist   (in_data.distance),
      .new_idx    (in_data.candidate_index),
      .prev_take  (prev_take),
      .prev_entry (prev_entry),
      .next_entry (entries[g+1]),
      .take       (takes[g]),
      .entry      (entries[g])
    );
  end

  // head cell is the next result; the list empties one step per transaction
  assign out_data.neighbor_index    = entries[0].idx;
  assign out_data.neighbor_distance = entries[0].distance;
  assign out_data.rank              = rank;
  assign out_data.last_result       = !entries[1].valid;

  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides open together");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entries[0].valid)
    else $error("draining an empty list");

  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_data.last_candidate) |=> (out_valid && rank == '0))
    else $error("last candidate did not start the drain at rank zero");

  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_data.last_result) |=> (in_ready && !entries[0].valid))
    else $error("list not empty after final result");

endmodule

// ----- verif/knn_topk_selector_tb.sv -----
`timescale 1ns / 1ps

module knn_topk_selector_tb;
  import knn_pkg::*;

  localparam int MAX_K        = 32;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 120;

  // sorted top-k list that mirrors the block, plus the neighbors it still owes
  class topk_scoreboard;
    logic [DIST_W-1:0] kept_dist [MAX_K];
    logic [IDX_W-1:0]  kept_idx [MAX_K];
    int unsigned       list_fill;
    logic [CFG_W-1:0]  k_setting;
    knn_out_t          expected_neighbors [$];
    int                mismatches;

    function new();
      list_fill  = 0;
      k_setting  = CFG_W'(K_RESET_VALUE);
      mismatches = 0;
    endfunction

    function void set_neighbors(logic [CFG_W-1:0] value);
      k_setting = value;
    endfunction

    function void note_candidate(knn_in_t c);
      int unsigned k;
      int pos;
      knn_out_t n;
      k = (k_setting == 0) ? 1 : (k_setting > MAX_K) ? MAX_K : k_setting;
      // a lowered k drops the worst entries before this candidate is looked at
      if (list_fill > k) list_fill = k;
      pos = -1;
      if (list_fill < k) begin
        pos = list_fill;
        list_fill++;
      end else if (c.distance < kept_dist[k-1]) begin
        pos = k - 1;
      end
      if (pos >= 0) begin
        // equal distances stay ahead of the newcomer
        while (pos > 0 && c.distance < kept_dist[pos-1]) begin
          kept_dist[pos] = kept_dist[pos-1];
          kept_idx[pos]  = kept_idx[pos-1];
          pos--;
        end
        kept_dist[pos] = c.distance;
        kept_idx[pos]  = c.candidate_index;
      end
      if (c.last_candidate) begin
        for (int r = 0; r < list_fill; r++) begin
          n.neighbor_index    = kept_idx[r];
          n.neighbor_distance = kept_dist[r];
          n.rank              = r[RANK_W-1:0];
          n.last_result       = (r + 1 == list_fill);
          expected_neighbors.push_back(n);
        end
        list_fill = 0;
      end
    endfunction

    task report(string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch: %s", what);
    endtask

    task check_result(knn_out_t got);
      knn_out_t want;
      if (expected_neighbors.size() == 0) begin
        report($sformatf("unexpected neighbor index %0d distance %0d",
                         got.neighbor_index, got.neighbor_distance));
        return;
      end
      want = expected_neighbors.pop_front();
      if (got.neighbor_index !== want.neighbor_index)
        report($sformatf("rank %0d neighbor_index got %0d want %0d",
                         want.rank, got.neighbor_index, want.neighbor_index));
      if (got.neighbor_distance !== want.neighbor_distance)
        report($sformatf("rank %0d neighbor_distance got %0h want %0h",
                         want.rank, got.neighbor_distance, want.neighbor_distance));
      if (got.rank !== want.rank)
        report($sformatf("rank got %0d want %0d", got.rank, want.rank));
      if (got.last_result !== want.last_result)
        report($sformatf("rank %0d last_result got %0b want %0b",
                         want.rank, got.last_result, want.last_result));
    endtask
  endclass

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  knn_in_t          in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  knn_out_t         out_data;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data  = '0;

  topk_scoreboard sb = new();
  int  in_idle_pct  = 23;
  int  out_idle_pct = 23;
  bit  hold_request = 1'b0;
  int  items_sent   = 0;
  int  cycle_count  = 0;

  knn_topk_selector #(
    .MAX_NEIGHBORS(MAX_K)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_result(out_data);
      if (in_valid && in_ready) sb.note_candidate(in_data);
      if (cfg_valid && cfg_ready) sb.set_neighbors(cfg_data);
    end
  end

  // result side: random back-pressure, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [DIST_W-1:0] rand_distance();
    case ($urandom_range(3))
      0, 1:    return $urandom();
      2:       return DIST_W'($urandom_range(15));  // dense range, many ties
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic send_candidate(input logic [DIST_W-1:0] cand_dist,
                                input logic [IDX_W-1:0] idx, input logic last);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{distance: cand_dist, candidate_index: idx, last_candidate: last};
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // no candidate in flight and every owed neighbor delivered
  task automatic wait_idle();
    in_valid <= 1'b0;
    // let the monitor note the transaction of the edge just passed
    @(posedge clk);
    while (sb.expected_neighbors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_neighbors(input logic [CFG_W-1:0] k);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= k;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int len;
    int split_at;
    int nq;
    int phase;
    int random_end;
    logic [CFG_W-1:0] k;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset value of k, single candidate at the top of every field
    send_candidate('1, '1, 1'b1);
    // ties keep arrival order, zero and all-ones distances
    send_candidate(32'd5, 16'd1, 1'b0);
    send_candidate(32'd5, 16'd2, 1'b0);
    send_candidate(32'd0, 16'd3, 1'b0);
    send_candidate('1, 16'd4, 1'b0);
    send_candidate(32'd5, 16'd5, 1'b1);
    // zero acts as one; an equal distance must not replace the kept one
    write_neighbors('0);
    send_candidate(32'd7, 16'd10, 1'b0);
    send_candidate(32'd7, 16'd11, 1'b0);
    send_candidate(32'd3, 16'd12, 1'b1);
    // full range of k, then lowered in the middle of a query
    write_neighbors(CFG_W'(MAX_K));
    send_candidate(32'd40, 16'd20, 1'b0);
    send_candidate(32'd10, 16'd21, 1'b0);
    send_candidate(32'd30, 16'd22, 1'b0);
    send_candidate(32'd20, 16'd23, 1'b0);
    send_candidate(32'd10, 16'd24, 1'b0);
    send_candidate(32'd50, 16'd25, 1'b0);
    write_neighbors(CFG_W'(2));
    send_candidate(32'd15, 16'd26, 1'b1);
    write_neighbors(CFG_W'(1));
    send_candidate(32'd9, 16'h8000, 1'b0);
    send_candidate(32'd8, 16'h7FFF, 1'b1);

    // first stretch without any idling on either side
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_end   = items_sent + RANDOM_ITEMS;
    phase        = 0;
    while (items_sent < random_end || phase <= 3) begin
      if (items_sent > random_end - RANDOM_ITEMS + 60) begin
        in_idle_pct  = 23;
        out_idle_pct = 23;
      end
      case ($urandom_range(4))
        0:       k = CFG_W'(1);
        1:       k = CFG_W'(MAX_K);
        2:       k = '1;
        3:       k = CFG_W'($urandom_range(2, 6));
        default: k = CFG_W'($urandom_range(63));
      endcase
      if (phase == 0) k = '1;
      write_neighbors(k);
      nq = (phase == 3) ? 3 : $urandom_range(1, 3);
      // results back up while candidates keep coming, so the input stalls
      if (phase == 3) hold_request = 1'b1;
      for (int q = 0; q < nq; q++) begin
        if (phase == 0 && q == 0)
          len = 40;
        else
          len = ($urandom_range(7) == 0) ? $urandom_range(33, 40) : $urandom_range(1, 12);
        split_at = ($urandom_range(4) == 0 && len > 2) ? $urandom_range(1, len - 1) : 0;
        for (int i = 0; i < len; i++) begin
          if (i > 0 && i == split_at) write_neighbors(CFG_W'($urandom_range(63)));
          send_candidate(rand_distance(), IDX_W'($urandom_range(65535)), i == len - 1);
        end
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_neighbors.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
